// ===== sv/clu_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// clu_pkg
// Shared types, constants and helpers of the complex LU matrix inverter.
// ---------------------------------------------------------------------------
package clu_pkg;

	localparam int DEF_MAX_DIM   = 8;
	localparam int DEF_FRAC_BITS = 16;
	localparam int DATA_W        = 32;
	localparam int CFG_W         = 4;
	// Wide accumulator: holds sums of full 64-bit products without wrapping.
	localparam int ACC_W         = 66;

	typedef enum logic [2:0] {
		RG_IN, RG_L, RG_U, RG_LI, RG_UI
	} region_t;

	typedef enum logic [2:0] {
		PH_FU, PH_FL, PH_IL, PH_IU, PH_OUT
	} phase_t;

	typedef enum logic [4:0] {
		S_LOAD, S_TASK, S_INIT, S_RDA, S_RDB, S_LATB,
		S_M0, S_M1, S_M2, S_M3, S_MACC, S_FIN,
		S_DLAT, S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6,
		S_DST, S_DWAIT, S_WR, S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OS_AR, OS_AI, OS_BR, OS_BI
	} opsel_t;

	typedef enum logic [2:0] {
		AOP_NONE, AOP_RE_P, AOP_RE_N, AOP_IM_P, AOP_DEN, AOP_DRE, AOP_DIM_P, AOP_DIM_N
	} aop_t;

	typedef struct packed {
		opsel_t x;
		opsel_t y;
		aop_t   aop;
	} mul_ctl_t;

	typedef struct packed {
		logic [63:0] num_re;
		logic        neg_re;
		logic [63:0] num_im;
		logic        neg_im;
		logic [63:0] den;
	} div_req_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-DATA_W:0] top;
		top = v[ACC_W-1:DATA_W-1];
		if ((&top) || !(|top)) begin
			return v[DATA_W-1:0];
		end
		return v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

endpackage
`default_nettype wire

// ===== sv/clu_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// clu_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module clu_ram #(
	parameter int AW = 9,
	parameter int DW = 64
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/clu_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// clu_div
// Bit-serial restoring divider for the real and imaginary quotients together.
// ---------------------------------------------------------------------------
module clu_div import clu_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire div_req_t                 req,
	output logic                          done,
	output logic                          zero_den,
	output logic signed [DATA_W-1:0]      q_re,
	output logic signed [DATA_W-1:0]      q_im
);

	localparam int ITER = 64 + FRAC_BITS;
	localparam int CNTW = $clog2(ITER + 1);

	logic            busy_q, done_q, zero_q;
	logic [CNTW-1:0] cnt_q;
	logic [63:0]     den_q, nre_q, nim_q, rre_q, rim_q;
	logic [32:0]     qre_q, qim_q;
	logic            ovre_q, ovim_q, negre_q, negim_q;

	logic [64:0] tre, tim, dre, dim;
	logic        gere, geim;

	always_comb begin
		tre  = {rre_q, nre_q[63]};
		tim  = {rim_q, nim_q[63]};
		gere = tre >= {1'b0, den_q};
		geim = tim >= {1'b0, den_q};
		dre  = tre - {1'b0, den_q};
		dim  = tim - {1'b0, den_q};
	end

	function automatic logic signed [DATA_W-1:0] finish(input logic [32:0] q, input logic ov,
			input logic neg);
		logic big;
		big = ov | q[32] | q[31];
		if (neg) begin
			return big ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed({1'b0, q[30:0]});
		end
		return big ? {1'b0, {(DATA_W-1){1'b1}}} : q[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				zero_q <= (req.den == 64'd0);
				if (req.den == 64'd0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNTW'(ITER);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q   <= req.den;
			nre_q   <= req.num_re;
			nim_q   <= req.num_im;
			rre_q   <= '0;
			rim_q   <= '0;
			qre_q   <= '0;
			qim_q   <= '0;
			ovre_q  <= 1'b0;
			ovim_q  <= 1'b0;
			negre_q <= (req.den == 64'd0) ? 1'b0 : req.neg_re;
			negim_q <= (req.den == 64'd0) ? 1'b0 : req.neg_im;
		end else if (busy_q) begin
			nre_q  <= {nre_q[62:0], 1'b0};
			nim_q  <= {nim_q[62:0], 1'b0};
			rre_q  <= gere ? dre[63:0] : tre[63:0];
			rim_q  <= geim ? dim[63:0] : tim[63:0];
			qre_q  <= {qre_q[31:0], gere};
			qim_q  <= {qim_q[31:0], geim};
			ovre_q <= ovre_q | qre_q[32];
			ovim_q <= ovim_q | qim_q[32];
		end
	end

	assign done     = done_q;
	assign zero_den = zero_q;
	assign q_re     = finish(qre_q, ovre_q, negre_q);
	assign q_im     = finish(qim_q, ovim_q, negim_q);

endmodule
`default_nettype wire

// ===== sv/complex_matrix_inverse_lu_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// complex_matrix_inverse_lu_unit
// Complex matrix inverse by Doolittle LU factorization on one shared multiplier.
// ---------------------------------------------------------------------------
// Usage: write the matrix size n through cfg_we/cfg_wdata while the block is
// idle (reset value 8). Then send n*n elements, row-major, on the input channel
// (in_valid/in_stall), which does not stall during the load. After the last
// element in_stall stays high while the block factors, inverts and multiplies.
// Every complex multiply-accumulate term runs four real products on the single
// 32x32 multiplier, and every complex division also runs the bit-serial
// divider. The n*n inverse elements then leave on the output channel
// (out_valid/out_stall) through a one-entry output register; last_elem marks
// the final one and singular marks every element of a matrix with a zero
// pivot. A stalled result holds the sequencer until its transfer.
// Input transfers resume once the final element sits in the output register.
// Reset clears the element count and the control state; the size register
// returns to 8. The storage needs no clearing pass.
// ---------------------------------------------------------------------------
module complex_matrix_inverse_lu_unit import clu_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_W-1:0]         cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [DATA_W-1:0] elem_re,
	input  wire logic signed [DATA_W-1:0] elem_im,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      inv_re,
	output logic signed [DATA_W-1:0]      inv_im,
	output logic                          last_elem,
	output logic                          singular
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int IW    = $clog2(MAX_DIM);
	localparam int NW    = $clog2(MAX_DIM + 1);
	localparam int CW    = $clog2(CELLS);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int AW    = 3 + CW;
	localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) << FRAC_BITS;

	state_t  state_q, state_d;
	phase_t  phase_q, nx_phase;
	logic [NW-1:0] n_q, t_q, t_lo, t_hi, dim_n;
	logic [IW-1:0] o_q, a_q, nx_o, nx_a;
	logic [LW-1:0] load_cnt_q;
	logic [CFG_W-1:0] msize_q;
	logic          last_task, o_last, a_last, use_div, sub_mode, last_load;
	logic          in_xfer, emit_go;

	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
	logic [63:0]              den_q;
	logic signed [DATA_W-1:0] opa_re_q, opa_im_q, opb_re_q, opb_im_q;
	logic signed [DATA_W-1:0] res_re_q, res_im_q;
	logic signed [63:0]       prod_s1;
	aop_t                     aop_s1;
	logic                     sing_q;
	logic                     out_valid_q, last_q;
	logic signed [DATA_W-1:0] out_re_q, out_im_q;
	logic                     out_sing_q;

	mul_ctl_t                 mctl;
	logic signed [DATA_W-1:0] mul_x, mul_y;
	region_t                  rg_sel;
	logic [IW-1:0]            row_sel, col_sel;
	logic [CW-1:0]            flat;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [63:0]              ram_wdata, ram_rdata;

	div_req_t                 dreq;
	logic                     div_start, div_done, div_zero;
	logic signed [DATA_W-1:0] div_re, div_im;

	logic signed [63:0]       sh_prod;
	logic signed [ACC_W-1:0]  ts, tu;

	// Effective size and load bookkeeping
	always_comb begin
		if (msize_q == '0) begin
			dim_n = NW'(1);
		end else if ((CFG_W + 1)'(msize_q) > (CFG_W + 1)'(MAX_DIM)) begin
			dim_n = NW'(MAX_DIM);
		end else begin
			dim_n = NW'(msize_q);
		end
		last_load = ((LW + 1)'(load_cnt_q) + (LW + 1)'(1))
			>= ((LW + 1)'(dim_n) * (LW + 1)'(dim_n));
	end

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != S_LOAD);
	assign emit_go  = !out_valid_q || !out_stall;

	// Task descriptors: inner range, divide and subtract modes
	always_comb begin
		o_last   = (NW'(o_q) == n_q - NW'(1));
		a_last   = (NW'(a_q) == n_q - NW'(1));
		use_div  = (phase_q == PH_FL) || (phase_q == PH_IU);
		sub_mode = (phase_q != PH_OUT);
		unique case (phase_q)
			PH_FU, PH_FL: begin
				t_lo = '0;
				t_hi = NW'(o_q);
			end
			PH_IL: begin
				t_lo = NW'(o_q);
				t_hi = NW'(a_q);
			end
			PH_IU: begin
				t_lo = NW'(a_q) + NW'(1);
				t_hi = NW'(o_q) + NW'(1);
			end
			PH_OUT: begin
				t_lo = (o_q > a_q) ? NW'(o_q) : NW'(a_q);
				t_hi = n_q;
			end
			default: begin
				t_lo = '0;
				t_hi = '0;
			end
		endcase
	end

	// Task order: factor row by row, then invert L and U column by column,
	// then form the product one result at a time.
	always_comb begin
		nx_phase  = phase_q;
		nx_o      = o_q;
		nx_a      = a_q + IW'(1);
		last_task = 1'b0;
		unique case (phase_q)
			PH_FU: begin
				if (a_last && o_last) begin
					nx_phase = PH_IL;
					nx_o     = '0;
					nx_a     = '0;
				end else if (a_last) begin
					nx_phase = PH_FL;
					nx_a     = o_q + IW'(1);
				end
			end
			PH_FL: begin
				if (a_last) begin
					nx_phase = PH_FU;
					nx_o     = o_q + IW'(1);
					nx_a     = o_q + IW'(1);
				end
			end
			PH_IL: begin
				if (a_last && o_last) begin
					nx_phase = PH_IU;
					nx_o     = '0;
					nx_a     = '0;
				end else if (a_last) begin
					nx_o = o_q + IW'(1);
					nx_a = o_q + IW'(1);
				end
			end
			PH_IU: begin
				if (a_q != '0) begin
					nx_a = a_q - IW'(1);
				end else if (o_last) begin
					nx_phase = PH_OUT;
					nx_o     = '0;
					nx_a     = '0;
				end else begin
					nx_o = o_q + IW'(1);
					nx_a = o_q + IW'(1);
				end
			end
			PH_OUT: begin
				if (a_last && o_last) begin
					last_task = 1'b1;
				end else if (a_last) begin
					nx_o = o_q + IW'(1);
					nx_a = '0;
				end
			end
			default: begin
				last_task = 1'b1;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD:  if (in_xfer && last_load) state_d = S_TASK;
			S_TASK:  state_d = S_INIT;
			S_INIT:  state_d = (t_lo < t_hi) ? S_RDA : S_FIN;
			S_RDA:   state_d = S_RDB;
			S_RDB:   state_d = S_LATB;
			S_LATB:  state_d = S_M0;
			S_M0:    state_d = S_M1;
			S_M1:    state_d = S_M2;
			S_M2:    state_d = S_M3;
			S_M3:    state_d = S_MACC;
			S_MACC:  state_d = ((t_q + NW'(1)) < t_hi) ? S_RDA : S_FIN;
			S_FIN: begin
				if (use_div) begin
					state_d = S_DLAT;
				end else begin
					state_d = (phase_q == PH_OUT) ? S_EMIT : S_WR;
				end
			end
			S_DLAT:  state_d = S_D0;
			S_D0:    state_d = S_D1;
			S_D1:    state_d = S_D2;
			S_D2:    state_d = S_D3;
			S_D3:    state_d = S_D4;
			S_D4:    state_d = S_D5;
			S_D5:    state_d = S_D6;
			S_D6:    state_d = S_DST;
			S_DST:   state_d = S_DWAIT;
			S_DWAIT: if (div_done) state_d = S_WR;
			S_WR:    state_d = S_TASK;
			S_EMIT: begin
				if (emit_go) begin
					state_d = last_task ? S_LOAD : S_TASK;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// Outputs of the sequencer: multiplier control and memory addressing
	always_comb begin
		mctl    = '{x: OS_AR, y: OS_BR, aop: AOP_NONE};
		rg_sel  = RG_IN;
		row_sel = o_q;
		col_sel = a_q;
		unique case (state_q)
			S_M0: mctl = '{x: OS_AR, y: OS_BR, aop: AOP_RE_P};
			S_M1: mctl = '{x: OS_AI, y: OS_BI, aop: AOP_RE_N};
			S_M2: mctl = '{x: OS_AR, y: OS_BI, aop: AOP_IM_P};
			S_M3: mctl = '{x: OS_AI, y: OS_BR, aop: AOP_IM_P};
			S_D0: mctl = '{x: OS_BR, y: OS_BR, aop: AOP_DEN};
			S_D1: mctl = '{x: OS_BI, y: OS_BI, aop: AOP_DEN};
			S_D2: mctl = '{x: OS_AR, y: OS_BR, aop: AOP_DRE};
			S_D3: mctl = '{x: OS_AI, y: OS_BI, aop: AOP_DRE};
			S_D4: mctl = '{x: OS_AI, y: OS_BR, aop: AOP_DIM_P};
			S_D5: mctl = '{x: OS_AR, y: OS_BI, aop: AOP_DIM_N};
			S_TASK: begin
				if (phase_q == PH_FL) begin
					row_sel = a_q;
					col_sel = o_q;
				end
			end
			S_RDA: begin
				unique case (phase_q)
					PH_FU:  begin rg_sel = RG_L;  row_sel = o_q; col_sel = t_q[IW-1:0]; end
					PH_IU:  begin rg_sel = RG_U;  row_sel = a_q; col_sel = t_q[IW-1:0]; end
					PH_OUT: begin rg_sel = RG_UI; row_sel = o_q; col_sel = t_q[IW-1:0]; end
					default: begin rg_sel = RG_L; row_sel = a_q; col_sel = t_q[IW-1:0]; end
				endcase
			end
			S_RDB: begin
				row_sel = t_q[IW-1:0];
				unique case (phase_q)
					PH_FU:  begin rg_sel = RG_U;  col_sel = a_q; end
					PH_FL:  begin rg_sel = RG_U;  col_sel = o_q; end
					PH_IL:  begin rg_sel = RG_LI; col_sel = o_q; end
					PH_IU:  begin rg_sel = RG_UI; col_sel = o_q; end
					default: begin rg_sel = RG_LI; col_sel = a_q; end
				endcase
			end
			S_FIN: begin
				rg_sel  = RG_U;
				row_sel = (phase_q == PH_FL) ? o_q : a_q;
				col_sel = row_sel;
			end
			S_WR: begin
				unique case (phase_q)
					PH_FU:  begin rg_sel = RG_U;  row_sel = o_q; col_sel = a_q; end
					PH_FL:  begin rg_sel = RG_L;  row_sel = a_q; col_sel = o_q; end
					PH_IL:  begin rg_sel = RG_LI; row_sel = a_q; col_sel = o_q; end
					default: begin rg_sel = RG_UI; row_sel = a_q; col_sel = o_q; end
				endcase
			end
			default: begin
				mctl = '{x: OS_AR, y: OS_BR, aop: AOP_NONE};
			end
		endcase
	end

	assign flat = CW'(CW'(row_sel) * CW'(n_q)) + CW'(col_sel);

	always_comb begin
		ram_we    = (state_q == S_WR) || in_xfer;
		ram_raddr = {rg_sel, flat};
		if (state_q == S_LOAD) begin
			ram_waddr = {RG_IN, load_cnt_q[CW-1:0]};
			ram_wdata = {elem_re, elem_im};
		end else begin
			ram_waddr = {rg_sel, flat};
			ram_wdata = {res_re_q, res_im_q};
		end
	end

	clu_ram #(
		.AW (AW),
		.DW (64)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared multiplier
	always_comb begin
		unique case (mctl.x)
			OS_AR:   mul_x = opa_re_q;
			OS_AI:   mul_x = opa_im_q;
			OS_BR:   mul_x = opb_re_q;
			default: mul_x = opb_im_q;
		endcase
		unique case (mctl.y)
			OS_AR:   mul_y = opa_re_q;
			OS_AI:   mul_y = opa_im_q;
			OS_BR:   mul_y = opb_re_q;
			default: mul_y = opb_im_q;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_x * mul_y;
	end

	// Scaled products round toward minus infinity, which is the arithmetic shift.
	always_comb begin
		sh_prod = prod_s1 >>> FRAC_BITS;
		ts      = $signed({{(ACC_W-64){sh_prod[63]}}, sh_prod});
		tu      = $signed({{(ACC_W-64){prod_s1[63]}}, prod_s1});
	end

	always_comb begin
		dreq.neg_re = acc_re_q[ACC_W-1];
		dreq.neg_im = acc_im_q[ACC_W-1];
		dreq.num_re = acc_re_q[ACC_W-1] ? 64'(-acc_re_q) : 64'(acc_re_q);
		dreq.num_im = acc_im_q[ACC_W-1] ? 64'(-acc_im_q) : 64'(acc_im_q);
		dreq.den    = den_q;
	end

	assign div_start = (state_q == S_DST);

	clu_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (dreq),
		.done     (div_done),
		.zero_den (div_zero),
		.q_re     (div_re),
		.q_im     (div_im)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			load_cnt_q  <= '0;
			msize_q     <= CFG_W'(8);
			aop_s1      <= AOP_NONE;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			aop_s1  <= mctl.aop;
			if (cfg_we) begin
				msize_q <= cfg_wdata;
			end
			if (in_xfer) begin
				load_cnt_q <= last_load ? '0 : load_cnt_q + LW'(1);
				if (last_load) begin
					sing_q <= 1'b0;
				end
			end
			if (state_q == S_DWAIT && div_done && div_zero) begin
				sing_q <= 1'b1;
			end
			if (state_q == S_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				if (in_xfer && last_load) begin
					n_q     <= dim_n;
					phase_q <= PH_FU;
					o_q     <= '0;
					a_q     <= '0;
				end
			end
			S_TASK: t_q <= t_lo;
			S_RDB: begin
				opa_re_q <= ram_rdata[63:32];
				opa_im_q <= ram_rdata[31:0];
			end
			S_LATB: begin
				opb_re_q <= ram_rdata[63:32];
				opb_im_q <= ram_rdata[31:0];
			end
			S_MACC: t_q <= t_q + NW'(1);
			S_FIN: begin
				res_re_q <= sat32(acc_re_q);
				res_im_q <= sat32(acc_im_q);
			end
			S_DLAT: begin
				opa_re_q <= res_re_q;
				opa_im_q <= res_im_q;
				opb_re_q <= ram_rdata[63:32];
				opb_im_q <= ram_rdata[31:0];
			end
			S_DWAIT: begin
				if (div_done) begin
					res_re_q <= div_re;
					res_im_q <= div_im;
				end
			end
			S_WR: begin
				phase_q <= nx_phase;
				o_q     <= nx_o;
				a_q     <= nx_a;
			end
			S_EMIT: begin
				if (emit_go) begin
					phase_q    <= nx_phase;
					o_q        <= nx_o;
					a_q        <= nx_a;
					out_re_q   <= res_re_q;
					out_im_q   <= res_im_q;
					out_sing_q <= sing_q;
					last_q     <= last_task;
				end
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	// Accumulators: the result of the previous multiplier cycle lands here.
	always_ff @(posedge clk) begin
		if (state_q == S_INIT) begin
			den_q <= '0;
			if (phase_q == PH_FU || phase_q == PH_FL) begin
				acc_re_q <= ACC_W'($signed(ram_rdata[63:32]));
				acc_im_q <= ACC_W'($signed(ram_rdata[31:0]));
			end else if ((phase_q == PH_IL || phase_q == PH_IU) && a_q == o_q) begin
				acc_re_q <= ONE;
				acc_im_q <= '0;
			end else begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end
		end else if (state_q == S_DLAT) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			den_q    <= '0;
		end else begin
			unique case (aop_s1)
				AOP_RE_P:  acc_re_q <= sub_mode ? acc_re_q - ts : acc_re_q + ts;
				AOP_RE_N:  acc_re_q <= sub_mode ? acc_re_q + ts : acc_re_q - ts;
				AOP_IM_P:  acc_im_q <= sub_mode ? acc_im_q - ts : acc_im_q + ts;
				AOP_DEN:   den_q    <= den_q + 64'(prod_s1);
				AOP_DRE:   acc_re_q <= acc_re_q + tu;
				AOP_DIM_P: acc_im_q <= acc_im_q + tu;
				AOP_DIM_N: acc_im_q <= acc_im_q - tu;
				default:   den_q    <= den_q;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign inv_re    = out_re_q;
	assign inv_im    = out_im_q;
	assign last_elem = last_q;
	assign singular  = out_sing_q;

`ifndef SYNTHESIS
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DWAIT)
		else $error("divider finished outside its wait state");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q < LW'(CELLS))
		else $error("element count ran past the storage");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && !emit_go |=> state_q == S_EMIT)
		else $error("sequencer left a result behind a stalled output");

	a_inner_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RDA |-> t_q < n_q)
		else $error("inner index outside the matrix");
`endif

endmodule
`default_nettype wire
